// ===== src/tkpd_pkg.sv =====
// shared types and codes for the touch key press detector
`default_nettype none
package tkpd_pkg;

  localparam int MODE_W    = 2;
  localparam int KEY_W     = 2;
  localparam int READING_W = 16;
  localparam int TIME_W    = 32;
  localparam int CFG_W     = 32;
  localparam int CFG_IDX_W = 1;

  typedef enum logic [1:0] {
    MODE_TOUCH  = 2'd0,
    MODE_POLL   = 2'd1,
    MODE_STATUS = 2'd2,
    MODE_NONE   = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_IDLE     = 2'd0,
    ST_PRESSED  = 2'd1,
    ST_LONG     = 2'd2,
    ST_RELEASED = 2'd3
  } key_state_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RELEASE_THRESHOLD = 1'b0,
    CFG_LONG_PRESS_MS     = 1'b1
  } cfg_index_t;

  localparam logic [READING_W-1:0] RELEASE_THRESHOLD_RST = 16'd50;
  localparam logic [TIME_W-1:0]    LONG_PRESS_MS_RST     = 32'd3000;

  typedef struct packed {
    logic [MODE_W-1:0]    mode;
    logic [KEY_W-1:0]     key;
    logic [READING_W-1:0] touch_reading;
    logic [TIME_W-1:0]    now_ms;
  } in_word_t;

  typedef struct packed {
    logic [KEY_W-1:0] key_out;
    logic [1:0]       key_state;
  } out_word_t;

endpackage
`default_nettype wire

// ===== src/touch_key_press_detector_top.sv =====
// touch key press detector: input register, update logic, result register
//
// usage:
//   in_valid/in_ready carry one word per key event: mode (touch, poll with
//   raw reading, status read), key index, reading and millisecond time.
//   out_valid/out_ready return one word per input word: the key and its state
//   (touch and poll give the state after the update, a status read gives the
//   state before a released key is cleared to idle).
//   cfg_we/cfg_index/cfg_wdata write release_threshold (index 0) and
//   long_press_ms (index 1); write them only while no word is in flight.
// path: an accepted word waits in the input register, then moves on to the
//   result register, where out_valid rises; the key state table is updated
//   as the word moves on.
// throughput: one word per cycle while the result is taken, with a
//   read-modify-write of the per-key state and press time registers.
// reset: all keys idle, press times zero, registers at 50 and 3000.
// stall: while out_ready is low the result holds; the input register still
//   takes one more word, then in_ready drops until the result is taken.
`default_nettype none
module touch_key_press_detector_top #(
  parameter int NUM_KEYS = 3
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire tkpd_pkg::in_word_t                in_data,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output tkpd_pkg::out_word_t                    out_data,
  input  wire logic                              cfg_we,
  input  wire logic [tkpd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [tkpd_pkg::CFG_W-1:0]        cfg_wdata
);

  logic [tkpd_pkg::READING_W-1:0] release_threshold_r;
  logic [tkpd_pkg::TIME_W-1:0]    long_press_ms_r;

  tkpd_pkg::in_word_t  in_r;
  logic                in_v_r;
  tkpd_pkg::out_word_t out_r;
  logic                out_v_r;

  tkpd_pkg::key_state_t          status_r   [NUM_KEYS];
  tkpd_pkg::key_state_t          status_nxt [NUM_KEYS];
  logic [tkpd_pkg::TIME_W-1:0]   ptime_r    [NUM_KEYS];
  logic [tkpd_pkg::TIME_W-1:0]   ptime_nxt  [NUM_KEYS];

  logic                          adv;
  logic                          key_ok;
  tkpd_pkg::key_state_t          cur;
  logic [tkpd_pkg::TIME_W-1:0]   cur_time;
  tkpd_pkg::key_state_t          new_state;
  logic [tkpd_pkg::TIME_W-1:0]   new_time;
  tkpd_pkg::key_state_t          rep_state;
  logic [tkpd_pkg::TIME_W-1:0]   elapsed;

  assign adv      = in_v_r && (!out_v_r || out_ready);
  assign in_ready = !in_v_r || adv;
  assign key_ok   = 32'(in_r.key) < 32'(NUM_KEYS);

  // select the addressed key
  always_comb begin
    cur      = tkpd_pkg::ST_IDLE;
    cur_time = '0;
    for (int k = 0; k < NUM_KEYS; k++) begin
      if (32'(in_r.key) == 32'(k)) begin
        cur      = status_r[k];
        cur_time = ptime_r[k];
      end
    end
  end

  assign elapsed = in_r.now_ms - cur_time;

  always_comb begin
    new_state = cur;
    new_time  = cur_time;
    rep_state = cur;
    case (tkpd_pkg::mode_t'(in_r.mode))
      tkpd_pkg::MODE_TOUCH: begin
        new_state = tkpd_pkg::ST_PRESSED;
        if (cur_time == '0) begin
          new_time = in_r.now_ms;
        end
        rep_state = tkpd_pkg::ST_PRESSED;
      end
      tkpd_pkg::MODE_POLL: begin
        if (cur == tkpd_pkg::ST_PRESSED || cur == tkpd_pkg::ST_LONG) begin
          if (in_r.touch_reading > release_threshold_r) begin
            new_state = tkpd_pkg::ST_RELEASED;
            new_time  = '0;
          end else if (elapsed > long_press_ms_r) begin
            new_state = tkpd_pkg::ST_LONG;
          end
        end
        rep_state = new_state;
      end
      tkpd_pkg::MODE_STATUS: begin
        if (cur == tkpd_pkg::ST_RELEASED) begin
          new_state = tkpd_pkg::ST_IDLE;
        end
      end
      default: begin
      end
    endcase
    if (!key_ok) begin
      rep_state = tkpd_pkg::ST_IDLE;
    end
  end

  always_comb begin
    for (int k = 0; k < NUM_KEYS; k++) begin
      status_nxt[k] = status_r[k];
      ptime_nxt[k]  = ptime_r[k];
      if (adv && key_ok && 32'(in_r.key) == 32'(k)) begin
        status_nxt[k] = new_state;
        ptime_nxt[k]  = new_time;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      release_threshold_r <= tkpd_pkg::RELEASE_THRESHOLD_RST;
      long_press_ms_r     <= tkpd_pkg::LONG_PRESS_MS_RST;
    end else if (cfg_we) begin
      case (tkpd_pkg::cfg_index_t'(cfg_index))
        tkpd_pkg::CFG_RELEASE_THRESHOLD:
          release_threshold_r <= cfg_wdata[tkpd_pkg::READING_W-1:0];
        tkpd_pkg::CFG_LONG_PRESS_MS:
          long_press_ms_r <= cfg_wdata[tkpd_pkg::TIME_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NUM_KEYS; k++) begin
        status_r[k] <= tkpd_pkg::ST_IDLE;
        ptime_r[k]  <= '0;
      end
    end else begin
      for (int k = 0; k < NUM_KEYS; k++) begin
        status_r[k] <= status_nxt[k];
        ptime_r[k]  <= ptime_nxt[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (in_ready) begin
        in_v_r <= in_valid;
      end
      if (adv) begin
        out_v_r <= 1'b1;
      end else if (out_ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_r <= in_data;
    end
    if (adv) begin
      out_r.key_out   <= in_r.key;
      out_r.key_state <= rep_state;
    end
  end

  assign out_valid = out_v_r;
  assign out_data  = out_r;

  // a touch on a real key always reports pressed
  a_touch_pressed: assert property (@(posedge clk) disable iff (!rst_n)
    adv && key_ok && in_r.mode == tkpd_pkg::MODE_TOUCH
    |=> out_r.key_state == tkpd_pkg::ST_PRESSED)
    else $error("touch did not report pressed");

  // keys outside the table report idle
  a_bad_key_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && 32'(out_r.key_out) >= 32'(NUM_KEYS)
    |-> out_r.key_state == tkpd_pkg::ST_IDLE)
    else $error("out of range key reported non-idle");

  // input side only stalls when the input register holds a word
  a_ready_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> in_v_r && out_v_r && !out_ready)
    else $error("input stalled without a blocked word");

  for (genvar g = 0; g < NUM_KEYS; g++) begin : g_chk
    // a released key never keeps a press time
    a_released_clear: assert property (@(posedge clk) disable iff (!rst_n)
      status_r[g] == tkpd_pkg::ST_RELEASED |-> ptime_r[g] == '0)
      else $error("released key holds a press time");
  end

endmodule
`default_nettype wire

// ===== sim/testbench.sv =====
// self-checking testbench for the touch key press detector
module testbench;

  localparam int NUM_KEYS     = 3;
  localparam int PHASE_WORDS  = 166;
  localparam int HOLD_CYCLES  = 300;
  localparam int LIMIT_CYCLES = 400000;

  // per-key state tracker: holds the expected result of every accepted word
  class key_tracker;
    logic [tkpd_pkg::READING_W-1:0] threshold;
    logic [tkpd_pkg::TIME_W-1:0]    long_limit;
    tkpd_pkg::key_state_t           key_st [NUM_KEYS];
    logic [tkpd_pkg::TIME_W-1:0]    held_since [NUM_KEYS];
    tkpd_pkg::out_word_t            pending_states [$];
    int                             errors;
    int                             checked;

    function new();
      threshold  = tkpd_pkg::RELEASE_THRESHOLD_RST;
      long_limit = tkpd_pkg::LONG_PRESS_MS_RST;
      foreach (key_st[i]) begin
        key_st[i]     = tkpd_pkg::ST_IDLE;
        held_since[i] = '0;
      end
      errors  = 0;
      checked = 0;
    endfunction

    function void write_reg(tkpd_pkg::cfg_index_t idx, logic [tkpd_pkg::CFG_W-1:0] data);
      if (idx == tkpd_pkg::CFG_RELEASE_THRESHOLD) begin
        threshold = data[tkpd_pkg::READING_W-1:0];
      end else begin
        long_limit = data[tkpd_pkg::TIME_W-1:0];
      end
    endfunction

    function void note_word(tkpd_pkg::in_word_t w);
      tkpd_pkg::out_word_t         res;
      tkpd_pkg::key_state_t        cur;
      logic [tkpd_pkg::TIME_W-1:0] elapsed;
      int                          k;
      k = w.key;
      res.key_out   = w.key;
      res.key_state = tkpd_pkg::ST_IDLE;
      if (k < NUM_KEYS) begin
        cur = key_st[k];
        res.key_state = cur;
        case (tkpd_pkg::mode_t'(w.mode))
          tkpd_pkg::MODE_TOUCH: begin
            key_st[k] = tkpd_pkg::ST_PRESSED;
            // a zero time means nothing is held yet
            if (held_since[k] == '0) held_since[k] = w.now_ms;
            res.key_state = key_st[k];
          end
          tkpd_pkg::MODE_POLL: begin
            if (cur == tkpd_pkg::ST_PRESSED || cur == tkpd_pkg::ST_LONG) begin
              elapsed = w.now_ms - held_since[k];
              if (w.touch_reading > threshold) begin
                key_st[k]     = tkpd_pkg::ST_RELEASED;
                held_since[k] = '0;
              end else if (elapsed > long_limit) begin
                key_st[k] = tkpd_pkg::ST_LONG;
              end
            end
            res.key_state = key_st[k];
          end
          tkpd_pkg::MODE_STATUS: begin
            if (cur == tkpd_pkg::ST_RELEASED) key_st[k] = tkpd_pkg::ST_IDLE;
          end
          default: ;
        endcase
      end
      pending_states.push_back(res);
    endfunction

    function void check_word(tkpd_pkg::out_word_t got);
      tkpd_pkg::out_word_t want;
      if (pending_states.size() == 0) begin
        $error("unexpected result: key_out %0d key_state %0d", got.key_out, got.key_state);
        errors++;
        return;
      end
      want = pending_states.pop_front();
      checked++;
      if (got.key_out !== want.key_out) begin
        $error("key_out: expected %0d, actual %0d", want.key_out, got.key_out);
        errors++;
      end
      if (got.key_state !== want.key_state) begin
        $error("key_state: expected %0d, actual %0d", want.key_state, got.key_state);
        errors++;
      end
    endfunction
  endclass

  logic                           clk       = 1'b0;
  logic                           rst_n     = 1'b0;
  logic                           in_valid  = 1'b0;
  logic                           in_ready;
  tkpd_pkg::in_word_t             in_data   = '0;
  logic                           out_valid;
  logic                           out_ready = 1'b0;
  tkpd_pkg::out_word_t            out_data;
  logic                           cfg_we    = 1'b0;
  logic [tkpd_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [tkpd_pkg::CFG_W-1:0]     cfg_wdata = '0;

  key_tracker  tracker = new();
  int          send_idle_pct = 0;
  int          stall_pct     = 0;
  logic        hold_go       = 1'b0;
  logic        hold_active   = 1'b0;
  logic [31:0] ms_now        = '0;
  int          words_sent    = 0;
  int          settings_done = 0;
  int          cycle_count   = 0;

  touch_key_press_detector_top #(.NUM_KEYS(NUM_KEYS)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  initial begin
    while (cycle_count < LIMIT_CYCLES) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("testbench: done, errors");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) tracker.note_word(in_data);
      if (out_valid && out_ready) tracker.check_word(out_data);
    end
  end

  always @(negedge clk) begin
    if (hold_active) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // long receiver hold-off so the block fills and stalls its input
  initial begin
    wait (hold_go);
    @(posedge clk);
    hold_active = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_active = 1'b0;
  end

  task automatic drive_word(input tkpd_pkg::in_word_t w);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic send_fields(input tkpd_pkg::mode_t m, input logic [1:0] k,
                             input logic [15:0] r, input logic [31:0] t);
    tkpd_pkg::in_word_t w;
    w.mode          = m;
    w.key           = k;
    w.touch_reading = r;
    w.now_ms        = t;
    drive_word(w);
    words_sent++;
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (tracker.pending_states.size() != 0) @(posedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input tkpd_pkg::cfg_index_t idx,
                           input logic [tkpd_pkg::CFG_W-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    tracker.write_reg(idx, data);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_idling(input int send_pct, input int recv_pct);
    @(posedge clk);
    send_idle_pct = send_pct;
    stall_pct     = recv_pct;
  endtask

  function automatic logic [15:0] reading_below();
    if ($urandom_range(2) == 0) return tracker.threshold;
    return 16'($urandom_range(tracker.threshold, 0));
  endfunction

  function automatic logic [15:0] reading_above();
    if (tracker.threshold == 16'hFFFF) return 16'hFFFF;
    if ($urandom_range(2) == 0) return tracker.threshold + 16'd1;
    return 16'($urandom_range(32'hFFFF, tracker.threshold + 1));
  endfunction

  // time steps: small, near the long-press limit, up to half of it, or random
  function automatic logic [31:0] step_ms();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 35) return $urandom_range(50);
    if (r < 60) return tracker.long_limit - 32'd2 + 32'($urandom_range(4));
    if (r < 85) return $urandom_range(tracker.long_limit / 2);
    return $urandom();
  endfunction

  task automatic send_noise();
    send_fields(tkpd_pkg::mode_t'($urandom_range(3)), 2'($urandom_range(3)),
                16'($urandom()), ($urandom_range(1) == 0) ? $urandom() : ms_now);
  endtask

  // touch, a few polls, usually a release, then status reads
  task automatic press_run();
    logic [1:0]  k;
    logic [31:0] t0;
    int          polls;
    k = 2'($urandom_range(NUM_KEYS - 1));
    if ($urandom_range(29) == 0) ms_now = ~32'($urandom_range(100));
    ms_now = ms_now + step_ms();
    t0 = ($urandom_range(19) == 0) ? 32'd0 : ms_now;
    send_fields(tkpd_pkg::MODE_TOUCH, k, 16'($urandom()), t0);
    polls = $urandom_range(5, 1);
    repeat (polls) begin
      if ($urandom_range(4) == 0) send_noise();
      ms_now = ms_now + step_ms();
      if ($urandom_range(5) == 0) begin
        send_fields(tkpd_pkg::MODE_TOUCH, k, 16'($urandom()), ms_now);
      end else begin
        send_fields(tkpd_pkg::MODE_POLL, k, reading_below(), ms_now);
      end
    end
    if ($urandom_range(3) != 0) begin
      ms_now = ms_now + step_ms();
      send_fields(tkpd_pkg::MODE_POLL, k, reading_above(), ms_now);
    end
    repeat ($urandom_range(2, 1)) begin
      send_fields(tkpd_pkg::MODE_STATUS, k, 16'($urandom()), ms_now);
    end
  endtask

  task automatic run_random(input int count);
    int target;
    target = words_sent + count;
    while (words_sent < target) begin
      if ($urandom_range(99) < 75) begin
        press_run();
      end else begin
        send_noise();
      end
    end
  endtask

  initial begin
    int          p;
    logic [15:0] thr;
    logic [31:0] lim;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed words at the reset register values
    send_fields(tkpd_pkg::MODE_STATUS, 2'd0, 16'h0000, 32'd0);
    send_fields(tkpd_pkg::MODE_POLL,   2'd0, 16'h0000, 32'd0);
    send_fields(tkpd_pkg::MODE_TOUCH,  2'd0, 16'hFFFF, 32'd0);     // time zero is not held
    send_fields(tkpd_pkg::MODE_TOUCH,  2'd0, 16'h0000, 32'd100);
    send_fields(tkpd_pkg::MODE_POLL,   2'd0, 16'd50,   32'd3100);  // exactly at the limit
    send_fields(tkpd_pkg::MODE_POLL,   2'd0, 16'd50,   32'd3101);
    send_fields(tkpd_pkg::MODE_TOUCH,  2'd0, 16'h0000, 32'd5000);
    send_fields(tkpd_pkg::MODE_POLL,   2'd0, 16'd51,   32'd5001);
    send_fields(tkpd_pkg::MODE_POLL,   2'd0, 16'h0000, 32'd5002);  // poll on a released key
    send_fields(tkpd_pkg::MODE_STATUS, 2'd0, 16'h0000, 32'd5003);
    send_fields(tkpd_pkg::MODE_STATUS, 2'd0, 16'h0000, 32'd5004);
    send_fields(tkpd_pkg::MODE_TOUCH,  2'd2, 16'h0000, 32'hFFFF_FFF0);
    send_fields(tkpd_pkg::MODE_POLL,   2'd2, 16'h0000, 32'h0000_0BB0); // elapsed wraps
    send_fields(tkpd_pkg::MODE_TOUCH,  2'd1, 16'h0000, 32'd1);
    send_fields(tkpd_pkg::MODE_NONE,   2'd1, 16'hFFFF, 32'hFFFF_FFFF);
    send_fields(tkpd_pkg::MODE_TOUCH,  2'd3, 16'hFFFF, 32'hFFFF_FFFF); // key out of range
    send_fields(tkpd_pkg::MODE_POLL,   2'd3, 16'hFFFF, 32'd7);
    send_fields(tkpd_pkg::MODE_STATUS, 2'd3, 16'h0000, 32'd8);
    send_fields(tkpd_pkg::MODE_NONE,   2'd3, 16'hAAAA, 32'h5555_5555);
    send_fields(tkpd_pkg::MODE_POLL,   2'd1, 16'hFFFF, 32'd2);
    send_fields(tkpd_pkg::MODE_POLL,   2'd2, 16'hFFFF, 32'hFFFF_FFFF);
    send_fields(tkpd_pkg::MODE_STATUS, 2'd2, 16'h0000, 32'd0);
    send_fields(tkpd_pkg::MODE_STATUS, 2'd1, 16'h0000, 32'd0);
    send_fields(tkpd_pkg::MODE_NONE,   2'd0, 16'h0000, 32'd0);
    wait_drained();

    for (p = 0; p < 8; p++) begin
      case (p)
        0: begin
          thr = tkpd_pkg::RELEASE_THRESHOLD_RST;
          lim = tkpd_pkg::LONG_PRESS_MS_RST;
        end
        1: begin thr = 16'd0;           lim = 32'd0; end
        2: begin thr = 16'hFFFF;        lim = 32'hFFFF_FFFF; end
        3: begin thr = 16'($urandom()); lim = $urandom_range(200, 1); end
        4: begin thr = 16'($urandom()); lim = tkpd_pkg::LONG_PRESS_MS_RST; end
        5: begin thr = 16'($urandom()); lim = $urandom(); end
        6: begin thr = 16'd1000;        lim = 32'd10; end
        default: begin thr = 16'($urandom()); lim = $urandom_range(5000); end
      endcase
      // upper data bits are don't-care for the 16-bit register
      write_reg(tkpd_pkg::CFG_RELEASE_THRESHOLD, {16'($urandom()), thr});
      write_reg(tkpd_pkg::CFG_LONG_PRESS_MS, lim);
      settings_done++;
      case (p % 4)
        0:       set_idling(0, 0);
        1:       set_idling(78, 0);
        2:       set_idling(0, 78);
        default: set_idling(19, 19);
      endcase
      if (p == 0) hold_go = 1'b1;
      run_random(PHASE_WORDS);
      wait_drained();
    end

    repeat (16) @(posedge clk);
    if (tracker.pending_states.size() != 0) begin
      $error("%0d results never arrived", tracker.pending_states.size());
      tracker.errors++;
    end
    $display("summary: %0d words over %0d register settings and four idling mixes",
             words_sent, settings_done);
    $display("summary: %0d results compared, %0d mismatches", tracker.checked,
             tracker.errors);
    if (tracker.errors == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
